[rtl/bcfac_pkg.sv]
// Shared types, constants and frame helpers for the boot command framer.
package bcfac_pkg;

  typedef struct packed {
    logic        kind;
    logic [2:0]  cmd_index;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last_of_run;
  } res_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_MISMATCH,
    ST_BADCMD,
    ST_IDLEACK
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_ALEN,
    PH_BODY
  } phase_t;

  typedef enum logic [4:0] {
    SL_LEN0, SL_LEN1, SL_LEN2, SL_LEN3,
    SL_MAG0, SL_MAG1,
    SL_CODE0, SL_CODE1,
    SL_SIZE0, SL_SIZE1,
    SL_DATA,
    SL_SUM0, SL_SUM1,
    SL_TMAG0, SL_TMAG1,
    SL_EA0, SL_EA1,
    SL_STAT
  } slot_t;

  localparam int unsigned NumSlots = 18;

  localparam logic [2:0]  CMD_COUNT  = 3'd6;
  localparam logic [7:0]  MAGIC_HDR  = 8'd2;
  localparam logic [7:0]  MAGIC_TAIL = 8'd3;
  localparam logic [7:0]  TAIL_MARK  = 8'hEA;
  localparam logic [16:0] HDR_BYTES  = 17'd10;

  typedef struct packed {
    logic [11:0] code;
    logic        ext_tail;
    logic        no_ack;
  } entry_t;

  typedef struct packed {
    logic        hdr;
    logic [15:0] size;
    logic [11:0] code;
    logic        has_byte;
    logic [7:0]  data;
    logic        tail;
    logic [15:0] sum;
    logic        ext_tail;
    logic        stat;
    status_t     status;
  } job_t;

  typedef struct packed {
    logic  found;
    slot_t slot;
  } slot_hit_t;

  function automatic entry_t cmd_lookup(logic [2:0] idx);
    entry_t e;
    e = '0;
    unique case (idx)
      3'd0:    e = '{code: 12'h086, ext_tail: 1'b1, no_ack: 1'b0};
      3'd1:    e = '{code: 12'h204, ext_tail: 1'b1, no_ack: 1'b0};
      3'd2:    e = '{code: 12'h205, ext_tail: 1'b0, no_ack: 1'b0};
      3'd3:    e = '{code: 12'h208, ext_tail: 1'b1, no_ack: 1'b1};
      3'd4:    e = '{code: 12'h802, ext_tail: 1'b1, no_ack: 1'b0};
      3'd5:    e = '{code: 12'h804, ext_tail: 1'b0, no_ack: 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic slot_en(job_t j, slot_t s);
    logic en;
    priority if (s <= SL_SIZE1) en = j.hdr;
    else if (s == SL_DATA)      en = j.has_byte;
    else if (s <= SL_TMAG1)     en = j.tail;
    else if (s <= SL_EA1)       en = j.tail & j.ext_tail;
    else if (s == SL_STAT)      en = j.stat;
    else                        en = 1'b0;
    return en;
  endfunction

  function automatic slot_hit_t slot_find(job_t j, logic [4:0] from);
    slot_hit_t h;
    h = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if ((5'(i) >= from) && slot_en(j, slot_t'(5'(i)))) begin
        h.found = 1'b1;
        h.slot  = slot_t'(5'(i));
      end
    end
    return h;
  endfunction

  function automatic res_t slot_result(job_t j, slot_t s);
    res_t        r;
    logic [16:0] total;
    total = {1'b0, j.size} + HDR_BYTES;
    r = '0;
    unique case (s)
      SL_LEN0:  r.tx_byte = total[7:0];
      SL_LEN1:  r.tx_byte = total[15:8];
      SL_LEN2:  r.tx_byte = {7'd0, total[16]};
      SL_LEN3:  r.tx_byte = 8'd0;
      SL_MAG0:  r.tx_byte = MAGIC_HDR;
      SL_MAG1:  r.tx_byte = 8'd0;
      SL_CODE0: r.tx_byte = j.code[7:0];
      SL_CODE1: r.tx_byte = {4'd0, j.code[11:8]};
      SL_SIZE0: r.tx_byte = j.size[7:0];
      SL_SIZE1: r.tx_byte = j.size[15:8];
      SL_DATA:  r.tx_byte = j.data;
      SL_SUM0:  r.tx_byte = j.sum[7:0];
      SL_SUM1:  r.tx_byte = j.sum[15:8];
      SL_TMAG0: r.tx_byte = MAGIC_TAIL;
      SL_TMAG1: r.tx_byte = 8'd0;
      SL_EA0:   r.tx_byte = TAIL_MARK;
      SL_EA1:   r.tx_byte = TAIL_MARK;
      SL_STAT: begin
        r.result_kind = 1'b1;
        r.status      = j.status;
      end
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/bcfac_front.sv]
// Front end: accepts items, tracks command and ack phase, issues burst jobs.
module bcfac_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  bcfac_pkg::cmd_t    cmd,
  input  logic               q_full,
  output logic               push,
  output bcfac_pkg::job_t    job
);

  bcfac_pkg::phase_t phase, phase_next;
  logic [15:0] sum, sum_next;
  logic [11:0] sent_code, sent_code_next;
  logic        ext_tail, ext_tail_next;
  logic        no_ack, no_ack_next;
  logic [31:0] ack_len, ack_len_next;
  logic [1:0]  alen_cnt, alen_cnt_next;
  logic [29:0] body_len, body_len_next;
  logic [31:0] body_cnt, body_cnt_next;
  logic [15:0] ack_code, ack_code_next;

  logic              acc;
  logic              in_idle;
  logic              bad_idx;
  logic              size_zero;
  bcfac_pkg::entry_t entry;
  logic [15:0]       sum_start;
  logic [15:0]       sum_after;
  logic [15:0]       tail_sum;
  logic              finish;
  logic              noack_eff;
  logic              long_eff;
  logic [11:0]       code_eff;
  logic [31:0]       len_new;
  logic [31:0]       len_round;
  logic [29:0]       blen_new;
  logic [15:0]       code_new;
  logic [31:0]       body_cnt_inc;
  logic              body_done;
  logic              match_alen;
  logic              match_body;

  assign cmd_ready    = !q_full;
  assign acc          = cmd_valid && cmd_ready;
  assign in_idle      = (phase == bcfac_pkg::PH_IDLE);
  assign entry        = bcfac_pkg::cmd_lookup(cmd.cmd_index);
  assign bad_idx      = (cmd.cmd_index >= bcfac_pkg::CMD_COUNT);
  assign size_zero    = (cmd.payload_len == 16'd0);
  assign sum_start    = cmd.payload_len + {4'd0, entry.code};
  assign sum_after    = (in_idle ? sum_start : sum) + {8'd0, cmd.data_byte};
  assign tail_sum     = (in_idle && size_zero) ? sum_start : sum_after;
  assign finish       = in_idle ? (size_zero || cmd.last) : cmd.last;
  assign noack_eff    = in_idle ? entry.no_ack : no_ack;
  assign long_eff     = in_idle ? entry.ext_tail : ext_tail;
  assign code_eff     = in_idle ? entry.code : sent_code;
  assign len_new      = ack_len | (32'(cmd.data_byte) << {alen_cnt, 3'b000});
  assign len_round    = len_new + 32'd3;
  assign blen_new     = len_round[31:2];
  assign body_cnt_inc = body_cnt + 32'd1;
  assign body_done    = (body_cnt_inc == {body_len, 2'b00});
  assign match_alen   = (ack_code == {4'd0, sent_code});
  assign match_body   = (code_new == {4'd0, sent_code});

  always_comb begin
    priority if (body_cnt == 32'd2) code_new = {ack_code[15:8], cmd.data_byte};
    else if (body_cnt == 32'd3)     code_new = {cmd.data_byte, ack_code[7:0]};
    else                            code_new = ack_code;
  end

  always_comb begin
    phase_next = phase;
    if (acc) begin
      unique case (phase)
        bcfac_pkg::PH_IDLE: begin
          if (!cmd.kind && !bad_idx) begin
            if (finish) begin
              phase_next = noack_eff ? bcfac_pkg::PH_IDLE : bcfac_pkg::PH_ALEN;
            end else begin
              phase_next = bcfac_pkg::PH_SEND;
            end
          end
        end
        bcfac_pkg::PH_SEND: begin
          if (!cmd.kind && cmd.last) begin
            phase_next = noack_eff ? bcfac_pkg::PH_IDLE : bcfac_pkg::PH_ALEN;
          end
        end
        bcfac_pkg::PH_ALEN: begin
          if (cmd.kind && (alen_cnt == 2'd3)) begin
            phase_next = (blen_new == 30'd0) ? bcfac_pkg::PH_IDLE : bcfac_pkg::PH_BODY;
          end
        end
        bcfac_pkg::PH_BODY: begin
          if (cmd.kind && body_done) begin
            phase_next = bcfac_pkg::PH_IDLE;
          end
        end
        default: phase_next = bcfac_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    push           = 1'b0;
    job            = '0;
    sum_next       = sum;
    sent_code_next = sent_code;
    ext_tail_next  = ext_tail;
    no_ack_next    = no_ack;
    ack_len_next   = ack_len;
    alen_cnt_next  = alen_cnt;
    body_len_next  = body_len;
    body_cnt_next  = body_cnt;
    ack_code_next  = ack_code;
    if (acc) begin
      if (!cmd.kind) begin
        priority if (in_idle && bad_idx) begin
          push       = 1'b1;
          job.stat   = 1'b1;
          job.status = bcfac_pkg::ST_BADCMD;
        end else if (in_idle || (phase == bcfac_pkg::PH_SEND)) begin
          push         = 1'b1;
          job.hdr      = in_idle;
          job.size     = cmd.payload_len;
          job.code     = code_eff;
          job.has_byte = !(in_idle && size_zero);
          job.data     = cmd.data_byte;
          if (in_idle) begin
            sent_code_next = entry.code;
            ext_tail_next  = entry.ext_tail;
            no_ack_next    = entry.no_ack;
          end
          sum_next = tail_sum;
          if (finish) begin
            job.tail     = 1'b1;
            job.sum      = tail_sum;
            job.ext_tail = long_eff;
            if (noack_eff) begin
              job.stat   = 1'b1;
              job.status = bcfac_pkg::ST_OK;
            end else begin
              ack_len_next  = 32'd0;
              alen_cnt_next = 2'd0;
              ack_code_next = {4'd0, code_eff};
            end
          end
        end else begin
          push = 1'b0;
        end
      end else begin
        unique case (phase)
          bcfac_pkg::PH_ALEN: begin
            ack_len_next  = len_new;
            alen_cnt_next = alen_cnt + 2'd1;
            if (alen_cnt == 2'd3) begin
              body_len_next = blen_new;
              body_cnt_next = 32'd0;
              if (blen_new == 30'd0) begin
                push       = 1'b1;
                job.stat   = 1'b1;
                job.status = match_alen ? bcfac_pkg::ST_OK : bcfac_pkg::ST_MISMATCH;
              end
            end
          end
          bcfac_pkg::PH_BODY: begin
            ack_code_next = code_new;
            body_cnt_next = body_cnt_inc;
            if (body_done) begin
              push       = 1'b1;
              job.stat   = 1'b1;
              job.status = match_body ? bcfac_pkg::ST_OK : bcfac_pkg::ST_MISMATCH;
            end
          end
          default: begin
            push       = 1'b1;
            job.stat   = 1'b1;
            job.status = bcfac_pkg::ST_IDLEACK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= bcfac_pkg::PH_IDLE;
      sum       <= '0;
      sent_code <= '0;
      ext_tail  <= 1'b0;
      no_ack    <= 1'b0;
      ack_len   <= '0;
      alen_cnt  <= '0;
      body_len  <= '0;
      body_cnt  <= '0;
      ack_code  <= '0;
    end else begin
      phase     <= phase_next;
      sum       <= sum_next;
      sent_code <= sent_code_next;
      ext_tail  <= ext_tail_next;
      no_ack    <= no_ack_next;
      ack_len   <= ack_len_next;
      alen_cnt  <= alen_cnt_next;
      body_len  <= body_len_next;
      body_cnt  <= body_cnt_next;
      ack_code  <= ack_code_next;
    end
  end

endmodule

[rtl/bcfac_queue.sv]
// Job queue between the front end and the output sequencer.
module bcfac_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bcfac_pkg::job_t wr_data,
  output logic            full,
  input  logic            pop,
  output bcfac_pkg::job_t rd_data,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bcfac_pkg::job_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/bcfac_back.sv]
// Output sequencer: expands queued jobs into frame bytes and status items.
module bcfac_back (
  input  logic            clk,
  input  logic            rst,
  input  bcfac_pkg::job_t q_data,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output bcfac_pkg::res_t res
);

  logic                 busy;
  bcfac_pkg::job_t      job;
  bcfac_pkg::slot_t     pos;
  logic                 advance;
  logic                 load;
  bcfac_pkg::res_t      cur;
  bcfac_pkg::res_t      res_next;
  bcfac_pkg::slot_hit_t nxt;
  bcfac_pkg::slot_hit_t first;

  assign advance = !res_valid || res_ready;
  assign cur     = bcfac_pkg::slot_result(job, pos);
  assign nxt     = bcfac_pkg::slot_find(job, 5'(pos) + 5'd1);
  assign first   = bcfac_pkg::slot_find(q_data, 5'd0);
  assign load    = advance && (!busy || !nxt.found) && !q_empty;
  assign q_pop   = load;

  always_comb begin
    res_next             = cur;
    res_next.last_of_run = !nxt.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= busy;
      if (load) begin
        busy <= 1'b1;
      end else if (busy && !nxt.found) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        res <= res_next;
      end
      if (load) begin
        job <= q_data;
        pos <= first.slot;
      end else if (busy) begin
        pos <= nxt.slot;
      end
    end
  end

endmodule

[rtl/boot_command_framer_ack_checker.sv]
// Top level of the boot command framer and ack checker.
// The first result of an item passes the job queue, the job register and the result register.
// Results leave at one per cycle while res_ready is high.
// Items are accepted every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Synchronous active-high reset returns to idle with all tracking state zero.
module boot_command_framer_ack_checker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bcfac_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output bcfac_pkg::res_t res
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  bcfac_pkg::job_t wr_job;
  bcfac_pkg::job_t rd_job;

  bcfac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  bcfac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_job),
    .full    (q_full),
    .pop     (pop),
    .rd_data (rd_job),
    .empty   (q_empty)
  );

  bcfac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (rd_job),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[rtl/bcfac_checker.sv]
// Port-level checks for the boot command framer, bound to the top level.
module bcfac_checker (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_ready,
  input bcfac_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind |-> res.last_of_run)
    else $error("status item not last of its run");

  a_tx_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.result_kind |-> res.status == bcfac_pkg::ST_OK)
    else $error("transmit item carries a status");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind boot_command_framer_ack_checker bcfac_checker u_bcfac_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
